[src/power_toggle_color_stepper_top_defines.svh]
// ---------------------------------------------------------------------------
// power_toggle_color_stepper_top_defines
// assertion macros used by the color stepper core
// ---------------------------------------------------------------------------
`ifndef POWER_TOGGLE_COLOR_STEPPER_TOP_DEFINES_SVH
`define POWER_TOGGLE_COLOR_STEPPER_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define PTCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PTCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ptcs_pkg.sv]
// ---------------------------------------------------------------------------
// ptcs_pkg
// types, codes and helper functions of the power toggle color stepper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptcs_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int COLOR_W    = 4;
    localparam int CFG_W      = 16;
    localparam int TIMER_BITS = 16;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [COLOR_W-1:0] NUM_COLORS  = 4'd8;
    localparam logic [COLOR_W-1:0] FIRST_COLOR = 4'd1;
    localparam logic [COLOR_W-1:0] NO_COLOR    = 4'd0;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_REQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd3;

    // register indexes (word address)
    localparam logic [1:0] REG_STEP   = 2'd0;
    localparam logic [1:0] REG_WAIT   = 2'd1;
    localparam logic [1:0] REG_TOGGLE = 2'd2;
    localparam logic [1:0] REG_SETTLE = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] STEP_RESET   = 16'd200;
    localparam logic [CFG_W-1:0] WAIT_RESET   = 16'd5500;
    localparam logic [CFG_W-1:0] TOGGLE_RESET = 16'd250;
    localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd5500;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CHG_ON     = 4'd1,
        PH_CHG_OFF    = 4'd2,
        PH_CHG_TAIL   = 4'd3,
        PH_RST_WAIT   = 4'd4,
        PH_RST_T1     = 4'd5,
        PH_RST_T2     = 4'd6,
        PH_RST_T3     = 4'd7,
        PH_RST_T4     = 4'd8,
        PH_RST_T5     = 4'd9,
        PH_RST_SETTLE = 4'd10
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] step_ticks;
        logic [CFG_W-1:0] reset_wait_ticks;
        logic [CFG_W-1:0] toggle_ticks;
        logic [CFG_W-1:0] settle_ticks;
    } cfg_t;

    // timer load, truncated or zero-extended to the timer width
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[TIMER_BITS-1:0];
    endfunction

    // color after c, with wrap from the last back to the first
    function automatic logic [COLOR_W-1:0] following_color(input logic [COLOR_W-1:0] c);
        return (c < NUM_COLORS) ? c + 4'd1 : FIRST_COLOR;
    endfunction

    // stored target if it names a color, else the current color
    function automatic logic [COLOR_W-1:0] target_of(input logic [COLOR_W-1:0] st,
                                                     input logic [COLOR_W-1:0] c);
        return (st inside {[FIRST_COLOR:NUM_COLORS]}) ? st : c;
    endfunction

endpackage

[src/ptcs_req_if.sv]
// ---------------------------------------------------------------------------
// ptcs_req_if
// request channel: operation, wanted level and target color
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptcs_req_if
    import ptcs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic               want_on;
    logic [COLOR_W-1:0] goal_color;

    modport source (output valid, output op, output want_on, output goal_color,
                    input ready);
    modport sink   (input valid, input op, input want_on, input goal_color,
                    output ready);
endinterface

[src/ptcs_res_if.sv]
// ---------------------------------------------------------------------------
// ptcs_res_if
// result channel: lamp level, believed color, busy flag and effect request
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptcs_res_if
    import ptcs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               light_on;
    logic [COLOR_W-1:0] shown_color;
    logic               busy_res;
    logic [COLOR_W-1:0] effect_request;

    modport source (output valid, output light_on, output shown_color,
                    output busy_res, output effect_request, input ready);
    modport sink   (input valid, input light_on, input shown_color,
                    input busy_res, input effect_request, output ready);
endinterface

[src/power_toggle_color_stepper_top.sv]
// Pipeline: an accepted word goes through the input register and then the result register.
// Throughput: one word per cycle; the only hold-off is a stalled result register.
// Timing of the lamp is counted in tick words, not clock cycles.
// Reset: rst_n clears state at once; color 1, lamp off, idle, default registers.
// ---------------------------------------------------------------------------
// power_toggle_color_stepper_top
// lamp color stepper with APB register file and stream request/result channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_toggle_color_stepper_top
    import ptcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ptcs_req_if.sink           req,
    ptcs_res_if.source         res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks       <= STEP_RESET;
            cfg_reg.reset_wait_ticks <= WAIT_RESET;
            cfg_reg.toggle_ticks     <= TOGGLE_RESET;
            cfg_reg.settle_ticks     <= SETTLE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_STEP:   cfg_reg.step_ticks       <= pwdata[CFG_W-1:0];
                REG_WAIT:   cfg_reg.reset_wait_ticks <= pwdata[CFG_W-1:0];
                REG_TOGGLE: cfg_reg.toggle_ticks     <= pwdata[CFG_W-1:0];
                default:    cfg_reg.settle_ticks     <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // register file reads
    always_comb
    begin
        case (paddr[3:2])
            REG_STEP:   prdata = PDATA_W'(cfg_reg.step_ticks);
            REG_WAIT:   prdata = PDATA_W'(cfg_reg.reset_wait_ticks);
            REG_TOGGLE: prdata = PDATA_W'(cfg_reg.toggle_ticks);
            default:    prdata = PDATA_W'(cfg_reg.settle_ticks);
        endcase
    end

    // controller
    ptcs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .res   (res)
    );

endmodule

[src/ptcs_core.sv]
// ---------------------------------------------------------------------------
// ptcs_core
// input register, single-pass state update and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "power_toggle_color_stepper_top_defines.svh"

module ptcs_core
    import ptcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    ptcs_req_if.sink    req,
    ptcs_res_if.source  res
);

    // input stage
    logic               s1_valid_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic               s1_want_reg;
    logic [COLOR_W-1:0] s1_target_reg;

    // controller state
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic                  changing_reg, changing_next;
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  want_reg, want_next;
    logic [COLOR_W-1:0]    stored_reg, stored_next;
    logic                  lamp_reg, lamp_next;
    logic [COLOR_W-1:0]    eff_next;

    // result stage
    logic               res_valid_reg;
    logic               res_light_reg;
    logic [COLOR_W-1:0] res_color_reg;
    logic               res_busy_reg;
    logic [COLOR_W-1:0] res_eff_reg;

    logic advance;

    // pipeline moves when the result register is free or being drained
    assign advance   = !res_valid_reg || res.ready;
    assign req.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg     <= req.op;
            s1_want_reg   <= req.want_on;
            s1_target_reg <= req.goal_color;
        end
    end

    // next state for one word
    always_comb
    begin
        logic do_apply;
        logic do_end;
        logic [COLOR_W-1:0] t;

        color_next    = color_reg;
        changing_next = changing_reg;
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        want_next     = want_reg;
        stored_next   = stored_reg;
        lamp_next     = lamp_reg;
        eff_next      = NO_COLOR;
        do_apply      = 1'b0;
        do_end        = 1'b0;
        t             = NO_COLOR;

        case (s1_op_reg)
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (timer_reg > TIMER_BITS'(1))
                    begin
                        timer_next = timer_reg - TIMER_BITS'(1);
                    end
                    else
                    begin
                        timer_next = '0;
                        do_end     = 1'b1;
                    end
                end
            end
            OP_REQ:
            begin
                want_next   = s1_want_reg;
                stored_next = s1_target_reg;
                do_apply    = !changing_reg;
            end
            OP_RESET:
            begin
                changing_next = 1'b1;
                lamp_next     = 1'b0;
                phase_next    = PH_RST_WAIT;
                timer_next    = timer_load(cfg.reset_wait_ticks);
            end
            default:
            begin
                eff_next = following_color(color_reg);
            end
        endcase

        // end of a timed phase
        if (do_end)
        begin
            case (phase_reg)
                PH_CHG_ON:
                begin
                    lamp_next  = 1'b0;
                    phase_next = PH_CHG_OFF;
                    timer_next = timer_load(cfg.step_ticks);
                end
                PH_CHG_OFF:
                begin
                    lamp_next  = 1'b1;
                    color_next = following_color(color_reg);
                    if (color_next != target_of(stored_reg, color_next))
                    begin
                        phase_next = PH_CHG_ON;
                        timer_next = timer_load(cfg.step_ticks);
                    end
                    else if (want_reg)
                    begin
                        changing_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_CHG_TAIL;
                        timer_next = timer_load(cfg.step_ticks);
                    end
                end
                PH_CHG_TAIL:
                begin
                    changing_next = 1'b0;
                    phase_next    = PH_IDLE;
                    do_apply      = 1'b1;
                end
                PH_RST_WAIT:
                begin
                    lamp_next  = 1'b1;
                    phase_next = PH_RST_T1;
                    timer_next = timer_load(cfg.toggle_ticks);
                end
                PH_RST_T1, PH_RST_T2, PH_RST_T3, PH_RST_T4:
                begin
                    lamp_next  = !lamp_reg;
                    phase_next = phase_t'(phase_reg + 4'd1);
                    timer_next = timer_load(cfg.toggle_ticks);
                end
                PH_RST_T5:
                begin
                    lamp_next  = !lamp_reg;
                    phase_next = PH_RST_SETTLE;
                    timer_next = timer_load(cfg.settle_ticks);
                end
                PH_RST_SETTLE:
                begin
                    color_next    = FIRST_COLOR;
                    changing_next = 1'b0;
                    phase_next    = PH_IDLE;
                    t             = target_of(stored_reg, FIRST_COLOR);
                    if (t != FIRST_COLOR)
                    begin
                        eff_next = t;
                    end
                end
                default:
                begin
                    phase_next    = PH_IDLE;
                    changing_next = 1'b0;
                end
            endcase
        end

        // apply the recorded on/off request
        if (do_apply)
        begin
            lamp_next = want_next;
            if (want_next)
            begin
                if (stored_next == NO_COLOR)
                begin
                    eff_next = color_next;
                end
                else if (target_of(stored_next, color_next) != color_next)
                begin
                    changing_next = 1'b1;
                    phase_next    = PH_CHG_ON;
                    timer_next    = timer_load(cfg.step_ticks);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= FIRST_COLOR;
            changing_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            want_reg     <= 1'b0;
            stored_reg   <= NO_COLOR;
            lamp_reg     <= 1'b0;
        end
        else if (s1_valid_reg && advance)
        begin
            color_reg    <= color_next;
            changing_reg <= changing_next;
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            want_reg     <= want_next;
            stored_reg   <= stored_next;
            lamp_reg     <= lamp_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            res_light_reg <= lamp_next;
            res_color_reg <= color_next;
            res_busy_reg  <= changing_next;
            res_eff_reg   <= eff_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.light_on       = res_light_reg;
    assign res.shown_color    = res_color_reg;
    assign res.busy_res       = res_busy_reg;
    assign res.effect_request = res_eff_reg;

    // checks
    `PTCS_ASSERT_ALWAYS(a_busy_matches_phase, (phase_reg == PH_IDLE) == !changing_reg, "busy flag and phase disagree")
    `PTCS_ASSERT_ALWAYS(a_color_range, (color_reg >= FIRST_COLOR) && (color_reg <= NUM_COLORS), "believed color out of range")
    `PTCS_ASSERT_NEXT(a_reset_starts, s1_valid_reg && advance && (s1_op_reg == OP_RESET), changing_reg && (phase_reg == PH_RST_WAIT) && !lamp_reg, "color reset did not start its wait phase")

endmodule
